// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, clocked on clk, off during reset.
`define EIFE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define EIFE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/eife_pkg.sv =====
// Package for the integer field encoder: kinds, constants, command types, helpers.
`timescale 1ns / 1ps

package eife_pkg;

	localparam int DEF_VALUE_WIDTH = 64;
	localparam int GROUP_BITS      = 7;
	localparam int FIELD_BITS_W    = 8;
	localparam int FIELD_WIDTH_W   = 4;
	localparam int VALUE_FIELD_W   = 64;
	localparam int COUNT_FIELD_W   = 4;
	localparam int KIND_W          = 3;
	localparam int S_TDATA_W       = 72;
	localparam int M_TDATA_W       = 16;

	localparam logic [FIELD_BITS_W-1:0]  CONT_FLAG  = 8'h80;
	localparam logic [FIELD_WIDTH_W-1:0] WIDTH_BYTE = 4'd8;
	localparam logic [FIELD_WIDTH_W-1:0] WIDTH_BIT  = 4'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_RAW  = 3'd0,
		KIND_BOOL = 3'd1,
		KIND_NBIT = 3'd2,
		KIND_UINT = 3'd3,
		KIND_SINT = 3'd4
	} kind_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic emit_group;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last_group;
	} dp_status_t;

	// Clamp a field width to 1..8.
	function automatic logic [FIELD_WIDTH_W-1:0] nb_sat(input logic [COUNT_FIELD_W-1:0] nb);
		logic [FIELD_WIDTH_W-1:0] r;
		if (nb == '0) begin
			r = WIDTH_BIT;
		end else if (nb > WIDTH_BYTE) begin
			r = WIDTH_BYTE;
		end else begin
			r = nb;
		end
		return r;
	endfunction

	// Low-bit mask for a clamped width of 1..8.
	function automatic logic [FIELD_BITS_W-1:0] nb_mask(input logic [FIELD_WIDTH_W-1:0] nb);
		return 8'hFF >> (WIDTH_BYTE - nb);
	endfunction

endpackage

// ===== rtl/eife_dp.sv =====
// Datapath: remaining-magnitude shift register and output field register.
`timescale 1ns / 1ps

module eife_dp import eife_pkg::*; #(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                      clk,
	input  kind_t                     kind,
	input  logic [VALUE_FIELD_W-1:0]  value,
	input  logic [COUNT_FIELD_W-1:0]  bit_count,
	input  dp_cmd_t                   cmd,
	output dp_status_t                status,
	output logic [FIELD_BITS_W-1:0]   field_bits,
	output logic [FIELD_WIDTH_W-1:0]  field_width,
	output logic                      last_field
);

	logic [VALUE_WIDTH-1:0]   val_m;
	logic                     sign;
	logic [FIELD_WIDTH_W-1:0] nb;
	logic [VALUE_WIDTH-1:0]   rem_q;
	logic [FIELD_BITS_W-1:0]  bits_q;
	logic [FIELD_WIDTH_W-1:0] width_q;
	logic                     last_q;

	assign val_m = value[VALUE_WIDTH-1:0];
	assign sign  = val_m[VALUE_WIDTH-1];
	assign nb    = nb_sat(bit_count);

	assign status.last_group = (rem_q[VALUE_WIDTH-1:GROUP_BITS] == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (kind)
				KIND_RAW: begin
					bits_q  <= val_m[FIELD_BITS_W-1:0];
					width_q <= WIDTH_BYTE;
					last_q  <= 1'b1;
				end
				KIND_BOOL: begin
					bits_q  <= {{(FIELD_BITS_W-1){1'b0}}, |val_m};
					width_q <= WIDTH_BIT;
					last_q  <= 1'b1;
				end
				KIND_NBIT: begin
					bits_q  <= val_m[FIELD_BITS_W-1:0] & nb_mask(nb);
					width_q <= nb;
					last_q  <= 1'b1;
				end
				KIND_UINT: begin
					rem_q <= val_m;
				end
				KIND_SINT: begin
					// Negative: encode magnitude minus one, i.e. the inverse
					bits_q  <= {{(FIELD_BITS_W-1){1'b0}}, sign};
					width_q <= WIDTH_BIT;
					last_q  <= 1'b0;
					rem_q   <= sign ? ~val_m : val_m;
				end
				default: begin
				end
			endcase
		end else if (cmd.emit_group) begin
			bits_q  <= {~status.last_group, rem_q[GROUP_BITS-1:0]};
			width_q <= WIDTH_BYTE;
			last_q  <= status.last_group;
			rem_q   <= rem_q >> GROUP_BITS;
		end
	end

	assign field_bits  = bits_q;
	assign field_width = width_q;
	assign last_field  = last_q;

endmodule

// ===== rtl/eife_ctrl.sv =====
// Controller: request acceptance, group sequencing and output valid.
`timescale 1ns / 1ps

module eife_ctrl import eife_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  kind_t      kind,
	output logic       m_tvalid,
	input  logic       m_tready,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	typedef enum logic {
		ST_IDLE,
		ST_GROUP
	} state_t;

	state_t state_q;
	logic   m_valid_q;
	logic   out_free;
	logic   accept;
	logic   kind_ok;

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign kind_ok  = (kind == KIND_RAW) || (kind == KIND_BOOL) || (kind == KIND_NBIT)
		|| (kind == KIND_UINT) || (kind == KIND_SINT);

	always_comb begin
		cmd.load       = accept;
		cmd.emit_group = (state_q == ST_GROUP) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && kind_ok) begin
						// Unsigned integers show nothing until the first group
						m_valid_q <= (kind != KIND_UINT);
						if (kind == KIND_UINT || kind == KIND_SINT) begin
							state_q <= ST_GROUP;
						end
					end else if (m_tready) begin
						m_valid_q <= 1'b0;
					end
				end
				ST_GROUP: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						if (status.last_group) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;

endmodule

// ===== rtl/exi_integer_field_encoder.sv =====
// Top level of the integer field encoder: stream ports, controller and datapath.
//
//  channel | direction | payload                                  | frame mark
//  s_      | in        | tuser: kind; tdata: value, bit_count      | -
//  m_      | out       | tdata: field_bits, field_width            | tlast: last_field
//
// Raw byte, boolean and n-bit kinds give one field; the next request can be taken as it leaves.
// Unsigned and signed integers emit one field per 7-bit group (1 to 10 groups) after the
// load, one group field per cycle while m_tready allows; a signed value first shows its sign field.
// A single output register holds each field; m_tready low stalls the group sequencer.
// arst_n clears the controller state and the output valid.
`timescale 1ns / 1ps

module exi_integer_field_encoder import eife_pkg::*; #(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // value [63:0], bit_count [67:64], zero pad
	input  logic [KIND_W-1:0]    s_tuser,   // kind [2:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // field_bits [7:0], field_width [11:8], zero pad
	output logic                 m_tlast    // last_field
);

	kind_t                    kind;
	dp_cmd_t                  cmd;
	dp_status_t               status;
	logic [FIELD_BITS_W-1:0]  field_bits;
	logic [FIELD_WIDTH_W-1:0] field_width;

	assign kind = kind_t'(s_tuser);

	eife_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.kind     (kind),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	eife_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.kind        (kind),
		.value       (s_tdata[VALUE_FIELD_W-1:0]),
		.bit_count   (s_tdata[VALUE_FIELD_W+COUNT_FIELD_W-1:VALUE_FIELD_W]),
		.cmd         (cmd),
		.status      (status),
		.field_bits  (field_bits),
		.field_width (field_width),
		.last_field  (m_tlast)
	);

	assign m_tdata = {{(M_TDATA_W-FIELD_BITS_W-FIELD_WIDTH_W){1'b0}}, field_width, field_bits};

endmodule

// ===== rtl/eife_checker.sv =====
// Port-level checker for the integer field encoder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eife_checker import eife_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tlast
);

	`EIFE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled field changed")
	`EIFE_ASSERT_IMP(a_width_range, m_tvalid, (m_tdata[11:8] != 4'd0) && (m_tdata[11:8] <= WIDTH_BYTE), "field width out of range")
	`EIFE_ASSERT_IMP(a_busy_mid_run, m_tvalid && !m_tlast, !s_tready, "new request taken inside a run")
	`EIFE_ASSERT_IMP(a_cont_flag, m_tvalid && !m_tlast && (m_tdata[11:8] == WIDTH_BYTE), m_tdata[7], "continuation flag missing")
	`EIFE_ASSERT_IMP(a_bit_field, m_tvalid && (m_tdata[11:8] == WIDTH_BIT), m_tdata[7:1] == 7'd0, "one-bit field has stray bits")

endmodule

bind exi_integer_field_encoder eife_checker u_eife_checker (.*);
